// ----- hw/rtl/mcrb_pkg.sv -----
// Shared types and constants of the multichannel sample ring buffer.
// No dependencies; mcrb_lane, mcrb_merge and the top level refer to it by scoped name.
package mcrb_pkg;

  localparam int unsigned LANE_W     = 24;  // width of one sample lane on the ports
  localparam int unsigned MAX_CH     = 8;   // lanes per frame, also number of banks
  localparam int unsigned CH_W       = 3;   // channel select / bank select width
  localparam int unsigned SPAN_W     = 4;   // holds a lane count 0..MAX_CH
  localparam int unsigned DEPTH_CFG_W = 9;  // active_depth register width

  // command codes
  localparam logic [1:0] CMD_INS_FRAME = 2'd0;
  localparam logic [1:0] CMD_RD_FRAME  = 2'd1;
  localparam logic [1:0] CMD_INS_CHAN  = 2'd2;
  localparam logic [1:0] CMD_RD_CHAN   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_DEPTH    = 2'd0;
  localparam logic [1:0] CFG_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_CLEAR    = 2'd2;

  // per-item access request broadcast to all banks
  typedef struct packed {
    logic              go;       // item accepted this cycle
    logic              insert;   // write samples, else read
    logic              zero_rd;  // read also writes zero back
    logic [SPAN_W-1:0] span;     // number of consecutive samples touched
  } lane_op_t;

  // what the merge stage needs to know about the item in flight
  typedef struct packed {
    logic              rd;       // item read samples
    logic              bad_ch;   // single-channel command on an inactive channel
    logic [CH_W-1:0]   off;      // bank holding the first sample
    logic [SPAN_W-1:0] span;
  } merge_info_t;

endpackage

// ----- hw/rtl/mcrb_ram.sv -----
// Generic single-port RAM with registered, read-before-write output.
// No dependencies.
module mcrb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mcrb_lane.sv -----
// One sample bank: works out whether and where the current item touches it,
// and holds the bank RAM. Depends on mcrb_pkg and mcrb_ram.
module mcrb_lane #(
  parameter int unsigned LANE      = 0,
  parameter int unsigned MAX_SLOTS = 256,
  parameter int unsigned STORE_W   = 24,
  localparam int unsigned PTR_W    = $clog2(MAX_SLOTS),
  localparam int unsigned IDX_W    = PTR_W + mcrb_pkg::CH_W
) (
  input  logic                                           clk_i,
  input  mcrb_pkg::lane_op_t                             op_i,
  input  logic [IDX_W-1:0]                               base_i,
  input  logic [mcrb_pkg::MAX_CH-1:0][mcrb_pkg::LANE_W-1:0] samples_i,
  input  logic                                           clr_i,
  input  logic [PTR_W-1:0]                               clr_row_i,
  output logic [STORE_W-1:0]                             rdata_o
);

  logic [mcrb_pkg::CH_W-1:0] k;
  logic [IDX_W-1:0]          idx;
  logic                      active;
  logic                      we;
  logic                      re;
  logic [PTR_W-1:0]          addr;
  logic [STORE_W-1:0]        wdata;

  // sample number k of the run lands in this bank
  assign k      = mcrb_pkg::CH_W'(LANE) - base_i[mcrb_pkg::CH_W-1:0];
  assign idx    = base_i + IDX_W'(k);
  assign active = op_i.go && ({1'b0, k} < op_i.span);

  assign we    = clr_i || (active && (op_i.insert || op_i.zero_rd));
  assign re    = !clr_i && active && !op_i.insert;
  assign addr  = clr_i ? clr_row_i : idx[IDX_W-1:mcrb_pkg::CH_W];
  assign wdata = (clr_i || !op_i.insert) ? '0 : samples_i[k][STORE_W-1:0];

  mcrb_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .addr_i  (addr),
    .we_i    (we),
    .wdata_i (wdata),
    .re_i    (re),
    .rdata_o (rdata_o)
  );

endmodule

// ----- hw/rtl/mcrb_merge.sv -----
// Merge stage: rotates bank read data back into channel order and zeroes
// unused lanes. Depends on mcrb_pkg.
module mcrb_merge #(
  parameter int unsigned STORE_W = 24
) (
  input  mcrb_pkg::merge_info_t                             info_i,
  input  logic [mcrb_pkg::MAX_CH-1:0][STORE_W-1:0]          bank_i,
  output logic [mcrb_pkg::MAX_CH-1:0][mcrb_pkg::LANE_W-1:0] lanes_o,
  output logic                                              status_o
);

  always_comb begin
    logic [mcrb_pkg::CH_W-1:0] src;
    for (int j = 0; j < mcrb_pkg::MAX_CH; j++) begin
      src = mcrb_pkg::CH_W'(j) + info_i.off;
      if (info_i.rd && (mcrb_pkg::SPAN_W'(j) < info_i.span)) begin
        lanes_o[j] = mcrb_pkg::LANE_W'(bank_i[src]);
      end else begin
        lanes_o[j] = '0;
      end
    end
  end

  assign status_o = info_i.bad_ch;

endmodule

// ----- hw/rtl/multichannel_sample_ring_buffer_unit.sv -----
// Top level of the multichannel sample ring buffer. Depends on mcrb_pkg,
// mcrb_lane, mcrb_ram and mcrb_merge.
//
// Interleaved audio ring buffer. Sample c of slot s lives at flat index
// active_channels*s + c; the store is split into eight banks by the low three
// bits of that index, so the up to eight consecutive samples of a frame sit in
// eight different banks and a frame insert or read is one access per bank,
// all banks in the same cycle. Every channel keeps its own write and read
// pointer; frame commands use channel 0's pointers, single-channel commands
// use their own. Pointers wrap at active_depth (0 acts as 1, larger than
// MAX_SLOTS acts as MAX_SLOTS). A single-channel command on a channel at or
// above active_channels returns status 1 with all lanes zero and changes
// nothing. Throughput: one transfer per cycle while the result side keeps
// up and no clearing pass runs; each result passes through the bank RAM read
// register, then through the merge into the output register. Each item
// produces exactly one result, inserts included. After reset the store is
// zeroed by a pass over all MAX_SLOTS bank rows, one row of all banks per
// cycle, with s_axis_tready low; configuration writes are taken meanwhile.
// Configuration must only be written while no item is in flight.
module multichannel_sample_ring_buffer_unit #(
  parameter int unsigned MAX_SLOTS   = 256,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [8:0]   cfg_wdata_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // in_lane_0 .. in_lane_7, 24 bits each
  input  logic [4:0]   s_axis_tuser,   // command[1:0], channel[4:2]
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // out_lane_0 .. out_lane_7, 24 bits each
  output logic [0:0]   m_axis_tuser    // status
);

  localparam int unsigned PTR_W   = $clog2(MAX_SLOTS);
  localparam int unsigned IDX_W   = PTR_W + mcrb_pkg::CH_W;
  localparam int unsigned STORE_W = (SAMPLE_BITS < mcrb_pkg::LANE_W) ? SAMPLE_BITS
                                                                      : mcrb_pkg::LANE_W;
  localparam int unsigned CMP_W   = (PTR_W + 1 > mcrb_pkg::DEPTH_CFG_W) ? PTR_W + 1
                                                                         : mcrb_pkg::DEPTH_CFG_W;

  // ---------------------------------------------------------------- config
  logic [mcrb_pkg::DEPTH_CFG_W-1:0] depth_q;
  logic [mcrb_pkg::SPAN_W-1:0]      chans_q;
  logic                             clr_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= mcrb_pkg::DEPTH_CFG_W'(256);
      chans_q  <= mcrb_pkg::SPAN_W'(8);
      clr_rd_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcrb_pkg::CFG_DEPTH:    depth_q  <= cfg_wdata_i;
        mcrb_pkg::CFG_CHANNELS: chans_q  <= cfg_wdata_i[mcrb_pkg::SPAN_W-1:0];
        mcrb_pkg::CFG_CLEAR:    clr_rd_q <= cfg_wdata_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // effective depth and channel count after clamping
  logic [CMP_W-1:0]            depth_eff;
  logic [mcrb_pkg::SPAN_W-1:0] nch;

  always_comb begin
    if (depth_q == '0) begin
      depth_eff = CMP_W'(1);
    end else if (CMP_W'(depth_q) > CMP_W'(MAX_SLOTS)) begin
      depth_eff = CMP_W'(MAX_SLOTS);
    end else begin
      depth_eff = CMP_W'(depth_q);
    end
    if (chans_q == '0) begin
      nch = mcrb_pkg::SPAN_W'(1);
    end else if (chans_q > mcrb_pkg::SPAN_W'(mcrb_pkg::MAX_CH)) begin
      nch = mcrb_pkg::SPAN_W'(mcrb_pkg::MAX_CH);
    end else begin
      nch = chans_q;
    end
  end

  // ---------------------------------------------------------- clearing pass
  logic             clr_q;
  logic [PTR_W-1:0] clr_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
    end else if (clr_q) begin
      if (clr_row_q == PTR_W'(MAX_SLOTS - 1)) begin
        clr_q <= 1'b0;
      end
      clr_row_q <= clr_row_q + PTR_W'(1);
    end
  end

  // ------------------------------------------------------------- handshake
  logic        pend_q;      // bank data waits for the merge stage
  logic        out_vld_q;
  logic        out_free;
  logic        load;
  logic        acc;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign load          = pend_q && out_free;
  assign s_axis_tready = !clr_q && (!pend_q || load);
  assign acc           = s_axis_tvalid && s_axis_tready;

  // ----------------------------------------------------------- decode item
  logic [1:0]                  cmd;
  logic [mcrb_pkg::CH_W-1:0]   ch;
  logic                        is_frame;
  logic                        is_insert;
  logic                        bad_ch;
  logic [mcrb_pkg::CH_W-1:0]   sel;
  logic [PTR_W-1:0]            ptr;
  logic [PTR_W:0]              ptr_inc;
  logic [PTR_W-1:0]            ptr_adv;
  logic [IDX_W-1:0]            base;
  logic [mcrb_pkg::SPAN_W-1:0] span;

  logic [mcrb_pkg::MAX_CH-1:0][PTR_W-1:0] wr_ptr_q;
  logic [mcrb_pkg::MAX_CH-1:0][PTR_W-1:0] rd_ptr_q;

  assign cmd       = s_axis_tuser[1:0];
  assign ch        = s_axis_tuser[4:2];
  assign is_frame  = (cmd == mcrb_pkg::CMD_INS_FRAME) || (cmd == mcrb_pkg::CMD_RD_FRAME);
  assign is_insert = (cmd == mcrb_pkg::CMD_INS_FRAME) || (cmd == mcrb_pkg::CMD_INS_CHAN);
  assign bad_ch    = !is_frame && ({1'b0, ch} >= nch);
  assign sel       = is_frame ? '0 : ch;
  assign ptr       = is_insert ? wr_ptr_q[sel] : rd_ptr_q[sel];

  // next pointer, wrapping at the active depth (also pulls in stale pointers)
  assign ptr_inc = {1'b0, ptr} + (PTR_W + 1)'(1);
  assign ptr_adv = (CMP_W'(ptr_inc) >= depth_eff) ? '0 : ptr_inc[PTR_W-1:0];

  // flat store index of the first sample touched
  assign base = IDX_W'(IDX_W'(nch) * IDX_W'(ptr)) + (is_frame ? '0 : IDX_W'(ch));
  assign span = bad_ch ? '0 : (is_frame ? nch : mcrb_pkg::SPAN_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else if (acc && !bad_ch) begin
      if (is_insert) begin
        wr_ptr_q[sel] <= ptr_adv;
      end else begin
        rd_ptr_q[sel] <= ptr_adv;
      end
    end
  end

  // ------------------------------------------------------------------ banks
  mcrb_pkg::lane_op_t op;
  logic [mcrb_pkg::MAX_CH-1:0][mcrb_pkg::LANE_W-1:0] samples;
  logic [mcrb_pkg::MAX_CH-1:0][STORE_W-1:0]          bank_rdata;

  assign op.go      = acc;
  assign op.insert  = is_insert;
  assign op.zero_rd = clr_rd_q;
  assign op.span    = span;
  assign samples    = s_axis_tdata;

  for (genvar b = 0; b < mcrb_pkg::MAX_CH; b++) begin : g_lane
    mcrb_lane #(
      .LANE      (b),
      .MAX_SLOTS (MAX_SLOTS),
      .STORE_W   (STORE_W)
    ) u_lane (
      .clk_i     (clk_i),
      .op_i      (op),
      .base_i    (base),
      .samples_i (samples),
      .clr_i     (clr_q),
      .clr_row_i (clr_row_q),
      .rdata_o   (bank_rdata[b])
    );
  end

  // ----------------------------------------------------------- merge / out
  mcrb_pkg::merge_info_t info_q;
  logic [mcrb_pkg::MAX_CH-1:0][mcrb_pkg::LANE_W-1:0] mrg_lanes;
  logic                                              mrg_status;
  logic [191:0]                                      out_data_q;
  logic                                              out_status_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      info_q.rd     <= !is_insert;
      info_q.bad_ch <= bad_ch;
      info_q.off    <= base[mcrb_pkg::CH_W-1:0];
      info_q.span   <= span;
    end
    if (load) begin
      out_data_q   <= mrg_lanes;
      out_status_q <= mrg_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  mcrb_merge #(
    .STORE_W (STORE_W)
  ) u_merge (
    .info_i   (info_q),
    .bank_i   (bank_rdata),
    .lanes_o  (mrg_lanes),
    .status_o (mrg_status)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule
